/* src/mpfr_pkg.sv */
// ----------------------------------------------------------------------------
// mpfr_pkg
// shared types and constants for the page framebuffer with refresh stream
// ----------------------------------------------------------------------------
package mpfr_pkg;

  // default screen geometry
  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 64;

  // widths fixed by the request fields
  localparam int COORD_W = 8;
  localparam int PAT_W   = 16;
  localparam int CNT_W   = 5;
  localparam int X_W     = COORD_W + 1;
  // stream position within one page, 0 .. width + 2, width up to 256
  localparam int POS_W   = 9;
  localparam int PAGE_W  = 3;
  localparam int S_DATA_W = 40;

  // limits on segment length
  localparam logic [CNT_W-1:0] BITMAP_MAX = 5'd8;
  localparam logic [CNT_W-1:0] GLYPH_MAX  = 5'd16;

  // panel command bytes
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  // request kinds carried on tuser
  typedef enum logic [2:0] {
    KIND_PIXEL   = 3'd0,
    KIND_FILL    = 3'd1,
    KIND_BITMAP  = 3'd2,
    KIND_GLYPH   = 3'd3,
    KIND_REFRESH = 3'd4
  } mpfr_kind_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_SEG,
    ST_SEG_WR,
    ST_REF_OUT
  } mpfr_state_t;

endpackage

/* src/mpfr_ram.sv */
// ----------------------------------------------------------------------------
// mpfr_ram
// generic simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module mpfr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/mono_page_framebuffer_refresh.sv */
// ----------------------------------------------------------------------------
// mono_page_framebuffer_refresh
// page-organised monochrome framebuffer with drawing requests and a
// byte-per-request refresh stream
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tuser kind, s_tdata col,row,color,pattern,count
//  m_*     | out | m_tvalid/m_tready  | m_tuser is_data, m_tdata out_byte, m_tlast frame_end
//
//  pixel, bitmap and glyph requests run one pixel at a time through a single
//  address adder and the ram read-modify-write port: after the accept, each drawn
//  pixel is read and then written back, a skipped pixel is stepped over, then it finishes.
//  fill and reset both sweep the store one byte a cycle over all width * pages
//  bytes (1024 at the default size); s_tready stays low during the sweep.
//  a refresh request waits for the output register to be free; the output
//  register lets drawing requests go on while a byte waits to be taken.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_refresh #(
  parameter int SCREEN_WIDTH  = mpfr_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = mpfr_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] col, [15:8] row, [16] color, [32:17] pattern, [37:33] count, [39:38] zero
  input  logic [mpfr_pkg::S_DATA_W-1:0] s_tdata,
  // [2:0] kind
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] out_byte
  output logic [7:0]  m_tdata,
  // [0] is_data
  output logic        m_tuser,
  // frame_end
  output logic        m_tlast
);

  localparam int PAGES  = (SCREEN_HEIGHT + 7) / 8;
  localparam int DEPTH  = SCREEN_WIDTH * PAGES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int BASE_W = ADDR_W + mpfr_pkg::PAGE_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [mpfr_pkg::POS_W-1:0] LAST_POS = mpfr_pkg::POS_W'(SCREEN_WIDTH + 2);
  localparam logic [mpfr_pkg::PAGE_W-1:0] LAST_PAGE = mpfr_pkg::PAGE_W'(PAGES - 1);
  localparam logic [mpfr_pkg::X_W-1:0] X_LIMIT = mpfr_pkg::X_W'(SCREEN_WIDTH);
  localparam logic [mpfr_pkg::X_W-1:0] Y_LIMIT = mpfr_pkg::X_W'(SCREEN_HEIGHT);

  // request fields
  logic [7:0]  in_col;
  logic [7:0]  in_row;
  logic        in_color;
  logic [15:0] in_pattern;
  logic [4:0]  in_count;

  assign in_col     = s_tdata[7:0];
  assign in_row     = s_tdata[15:8];
  assign in_color   = s_tdata[16];
  assign in_pattern = s_tdata[32:17];
  assign in_count   = s_tdata[37:33];

  mpfr_pkg::mpfr_state_t state, state_next;

  // sweep
  logic [ADDR_W-1:0] sweep_addr;
  logic              fill_val;

  // segment walker
  logic [mpfr_pkg::X_W-1:0]   seg_x;
  logic                       seg_row_ok;
  logic [2:0]                 seg_bit;
  logic [ADDR_W-1:0]          seg_base;
  logic [mpfr_pkg::PAT_W-1:0] seg_pat;
  logic [mpfr_pkg::CNT_W-1:0] seg_cnt;
  logic                       seg_glyph;
  logic                       seg_color;

  // refresh position
  logic [mpfr_pkg::PAGE_W-1:0] ref_page;
  logic [mpfr_pkg::POS_W-1:0]  ref_pos;

  // ram port signals
  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [7:0]        ram_wr_data;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [7:0]        ram_rd_data;

  // shared address adder
  logic [ADDR_W-1:0] addr_base;
  logic [ADDR_W-1:0] addr_off;
  logic [ADDR_W-1:0] addr_sum;

  logic              accept;
  logic              out_free;
  logic              pix_hit;
  logic              pix_val;
  logic [7:0]        pix_mask;
  logic              ref_is_data;
  logic [ADDR_W-1:0] ref_base;
  logic [ADDR_W-1:0] row_base;
  logic [7:0]        ref_byte;
  logic              ref_end;
  logic [mpfr_pkg::CNT_W-1:0] bitmap_cnt;
  logic [mpfr_pkg::CNT_W-1:0] glyph_cnt;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // page base addresses, product of a page number and a constant width
  assign ref_base = ADDR_W'(BASE_W'(ref_page) * BASE_W'(SCREEN_WIDTH));
  assign row_base = ADDR_W'(BASE_W'(in_row[5:3]) * BASE_W'(SCREEN_WIDTH));

  // current pixel of the segment
  assign pix_hit  = seg_row_ok && (seg_x < X_LIMIT) && (seg_glyph || seg_pat[15]);
  assign pix_val  = seg_glyph ? ~(seg_pat[15] ^ seg_color) : 1'b1;
  assign pix_mask = 8'(8'h01 << seg_bit);

  assign ref_is_data = ref_pos > mpfr_pkg::POS_W'(2);
  assign addr_sum    = addr_base + addr_off;

  // segment length limits
  assign bitmap_cnt = (in_count > mpfr_pkg::BITMAP_MAX) ? mpfr_pkg::BITMAP_MAX : in_count;
  assign glyph_cnt  = (in_count > mpfr_pkg::GLYPH_MAX) ? mpfr_pkg::GLYPH_MAX : in_count;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mpfr_pkg::ST_SWEEP: begin
        if (sweep_addr == LAST_ADDR) state_next = mpfr_pkg::ST_IDLE;
      end
      mpfr_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          unique case (s_tuser)
            mpfr_pkg::KIND_PIXEL,
            mpfr_pkg::KIND_BITMAP,
            mpfr_pkg::KIND_GLYPH:   state_next = mpfr_pkg::ST_SEG;
            mpfr_pkg::KIND_FILL:    state_next = mpfr_pkg::ST_SWEEP;
            mpfr_pkg::KIND_REFRESH: state_next = mpfr_pkg::ST_REF_OUT;
            default:                state_next = mpfr_pkg::ST_IDLE;
          endcase
        end
      end
      mpfr_pkg::ST_SEG: begin
        if (seg_cnt == '0) state_next = mpfr_pkg::ST_IDLE;
        else if (pix_hit)  state_next = mpfr_pkg::ST_SEG_WR;
      end
      mpfr_pkg::ST_SEG_WR: begin
        state_next = mpfr_pkg::ST_SEG;
      end
      mpfr_pkg::ST_REF_OUT: begin
        if (out_free) state_next = mpfr_pkg::ST_IDLE;
      end
      default: state_next = mpfr_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, adder operands and ram ports
  always_comb begin
    s_tready    = 1'b0;
    addr_base   = seg_base;
    addr_off    = ADDR_W'(seg_x);
    ram_rd_en   = 1'b0;
    ram_rd_addr = addr_sum;
    ram_wr_en   = 1'b0;
    ram_wr_addr = addr_sum;
    ram_wr_data = pix_val ? (ram_rd_data | pix_mask) : (ram_rd_data & ~pix_mask);
    unique case (state)
      mpfr_pkg::ST_SWEEP: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = sweep_addr;
        ram_wr_data = {8{fill_val}};
      end
      mpfr_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        addr_base = ref_base;
        addr_off  = ADDR_W'(ref_pos - mpfr_pkg::POS_W'(3));
        ram_rd_en = s_tvalid && (s_tuser == mpfr_pkg::KIND_REFRESH) && ref_is_data;
      end
      mpfr_pkg::ST_SEG: begin
        ram_rd_en = pix_hit && (seg_cnt != '0);
      end
      mpfr_pkg::ST_SEG_WR: begin
        ram_wr_en = 1'b1;
      end
      mpfr_pkg::ST_REF_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // refresh byte selection
  always_comb begin
    priority case (ref_pos)
      mpfr_pkg::POS_W'(0): ref_byte = mpfr_pkg::CMD_PAGE_BASE + 8'(ref_page);
      mpfr_pkg::POS_W'(1): ref_byte = mpfr_pkg::CMD_COL_LOW;
      mpfr_pkg::POS_W'(2): ref_byte = mpfr_pkg::CMD_COL_HIGH;
      default:             ref_byte = ram_rd_data;
    endcase
  end

  assign ref_end = (ref_pos == LAST_POS) && (ref_page == LAST_PAGE);

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mpfr_pkg::ST_SWEEP;
      sweep_addr <= '0;
      fill_val   <= 1'b0;
      ref_page   <= '0;
      ref_pos    <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;

      // store sweep for reset and fill
      if (state == mpfr_pkg::ST_SWEEP) begin
        sweep_addr <= sweep_addr + ADDR_W'(1);
      end else if (accept && (s_tuser == mpfr_pkg::KIND_FILL)) begin
        sweep_addr <= '0;
        fill_val   <= in_color;
      end

      // output register
      if ((state == mpfr_pkg::ST_REF_OUT) && out_free) begin
        m_tvalid <= 1'b1;
        if (ref_pos == LAST_POS) begin
          ref_pos  <= '0;
          ref_page <= (ref_page == LAST_PAGE) ? '0 : ref_page + 3'd1;
        end else begin
          ref_pos <= ref_pos + mpfr_pkg::POS_W'(1);
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if ((state == mpfr_pkg::ST_REF_OUT) && out_free) begin
      m_tdata <= ref_byte;
      m_tuser <= ref_is_data;
      m_tlast <= ref_end;
    end

    // segment setup
    if (accept) begin
      seg_x      <= mpfr_pkg::X_W'(in_col);
      seg_row_ok <= mpfr_pkg::X_W'(in_row) < Y_LIMIT;
      seg_bit    <= in_row[2:0];
      seg_base   <= row_base;
      seg_color  <= in_color;
      seg_glyph  <= s_tuser != mpfr_pkg::KIND_BITMAP;
      priority case (s_tuser)
        mpfr_pkg::KIND_PIXEL: begin
          seg_cnt <= mpfr_pkg::CNT_W'(1);
          seg_pat <= 16'h8000;
        end
        mpfr_pkg::KIND_BITMAP: begin
          seg_cnt <= bitmap_cnt;
          seg_pat <= {in_pattern[7:0], 8'h00};
        end
        default: begin
          seg_cnt <= glyph_cnt;
          seg_pat <= in_pattern;
        end
      endcase
    end else if ((state == mpfr_pkg::ST_SEG_WR) ||
                 ((state == mpfr_pkg::ST_SEG) && !pix_hit && (seg_cnt != '0))) begin
      // step to the next pixel after a write or a skipped pixel
      seg_x   <= seg_x + mpfr_pkg::X_W'(1);
      seg_pat <= {seg_pat[14:0], 1'b0};
      seg_cnt <= seg_cnt - mpfr_pkg::CNT_W'(1);
    end
  end

  mpfr_ram #(
    .WIDTH  (8),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // a byte appears on the output only out of the refresh state
  a_out_from_refresh: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == mpfr_pkg::ST_REF_OUT))
    else $error("output byte without a refresh request");

  // frame end only on a display data byte
  a_end_is_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser)
    else $error("frame end on a command byte");

  // command bytes are one of the three page header bytes
  a_cmd_bytes: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |->
      (m_tdata == mpfr_pkg::CMD_COL_LOW) || (m_tdata == mpfr_pkg::CMD_COL_HIGH) ||
      (m_tdata[7:4] == mpfr_pkg::CMD_PAGE_BASE[7:4]))
    else $error("bad command byte");

  // refresh page stays on the screen
  a_page_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, ref_page} < 4'(PAGES))
    else $error("refresh page out of range");

  // the store is written only by the sweep or a pixel update
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> (state == mpfr_pkg::ST_SWEEP) || (state == mpfr_pkg::ST_SEG_WR))
    else $error("unexpected store write");

endmodule
